// ===== rtl/rsdg_pkg.sv =====
// ----------------------------------------------------------------------------
// Random segment drift generator package
// Shared widths, register codes, reset values and sequencer types.
// ----------------------------------------------------------------------------
`default_nettype none

package rsdg_pkg;

    localparam int GAIN_W       = 16;
    localparam int LREG_W       = 20;
    localparam int RAND_W       = 16;
    localparam int SAMPLE_W     = 16;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = LREG_W;
    localparam int MUL_STEPS    = 16;
    localparam int MUL_IDX_W    = 4;

    localparam int LENGTH_BITS_DEF   = 20;
    localparam int FRACTION_BITS_DEF = 32;

    localparam logic [GAIN_W-1:0] GAIN_RST    = 16'd655;
    localparam logic [LREG_W-1:0] MIN_LEN_RST = 20'd11429;
    localparam logic [LREG_W-1:0] MAX_LEN_RST = 20'd21818;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GAIN    = 2'd0,
        CFG_MIN_LEN = 2'd1,
        CFG_MAX_LEN = 2'd2
    } t_cfg_reg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIFF,
        ST_LMUL,
        ST_LEN,
        ST_DIV,
        ST_NEG,
        ST_OMUL,
        ST_FIN
    } t_state;

    typedef enum logic {
        ALU_ADD,
        ALU_SUB
    } t_alu_op;

endpackage

`default_nettype wire

// ===== rtl/rsdg_alu.sv =====
// ----------------------------------------------------------------------------
// Shared adder/subtractor
// The single arithmetic unit that the sequencer uses for every step of the
// length product, the slope division, the output product and the level update.
// ----------------------------------------------------------------------------
`default_nettype none

module rsdg_alu
    import rsdg_pkg::*;
#(
    parameter int W = FRACTION_BITS_DEF + 21
) (
    input  wire t_alu_op       i_op,
    input  wire logic [W-1:0]  i_a,
    input  wire logic [W-1:0]  i_b,
    output logic      [W-1:0]  o_y
);

    always_comb begin
        unique case (i_op)
            ALU_ADD: o_y = i_a + i_b;
            ALU_SUB: o_y = i_a - i_b;
            default: o_y = i_a + i_b;
        endcase
    end

endmodule

`default_nettype wire

// ===== rtl/random_segment_drift_generator_top.sv =====
// ----------------------------------------------------------------------------
// Random segment drift generator
// Piecewise-linear random drift source producing one gained Q1.15 sample for
// every sample tick transaction.
// ----------------------------------------------------------------------------
// One shared adder runs under a small sequencer, so the block takes one tick
// at a time and drops o_in_ready while it works. A tick inside a segment runs
// from acceptance through 16 shift-add steps of the gain product and a finish
// step until the block is ready again. A tick that starts a new segment first
// runs the length difference, 16 steps of the length product, the length sum,
// FRACTION_BITS + 1 steps of the restoring slope division and the slope sign,
// then the gain product and finish. The finished sample waits in an output
// register, so a new tick is accepted while it is still unread; the finish
// step waits only if the previous sample has not yet been taken.
// ----------------------------------------------------------------------------
`default_nettype none

module random_segment_drift_generator_top
    import rsdg_pkg::*;
#(
    parameter int LENGTH_BITS   = LENGTH_BITS_DEF,
    parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
    input  wire                         i_clk,
    input  wire                         i_rst_n,
    input  wire                         i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  i_cfg_data,
    input  wire                         i_in_valid,
    output logic                        o_in_ready,
    input  wire logic [RAND_W-1:0]      i_rand_length,
    input  wire logic signed [RAND_W-1:0] i_rand_level,
    output logic                        o_out_valid,
    input  wire                         i_out_ready,
    output logic signed [SAMPLE_W-1:0]  o_sample,
    output logic                        o_segment_started
);

    localparam int LMW         = (LENGTH_BITS < LREG_W) ? LENGTH_BITS : LREG_W;
    localparam int QW          = FRACTION_BITS + 1;
    localparam int AW          = FRACTION_BITS + 3;
    localparam int PW          = FRACTION_BITS + 21;
    localparam int RW          = LMW + 1;
    localparam int STEP_W      = $clog2(QW);
    localparam int LEVEL_SHIFT = FRACTION_BITS - 15;
    localparam int OUT_SHIFT   = FRACTION_BITS + 1;

    localparam logic signed [PW-1:0] SAT_HI = PW'(32767);
    localparam logic signed [PW-1:0] SAT_LO = -SAT_HI - PW'(1);

    t_state                    r_state, n_state;
    logic [GAIN_W-1:0]         r_gain;
    logic [LREG_W-1:0]         r_min_len;
    logic [LREG_W-1:0]         r_max_len;
    logic signed [AW-1:0]      r_acc;
    logic signed [AW-1:0]      r_slope;
    logic signed [RAND_W-1:0]  r_target;
    logic [LENGTH_BITS-1:0]    r_count;
    logic [LENGTH_BITS-1:0]    r_seg_len;
    logic [STEP_W-1:0]         r_step;
    logic                      r_out_valid;

    logic [RAND_W-1:0]         r_frac;
    logic signed [RAND_W-1:0]  r_new_level;
    logic                      r_started;
    logic [LMW-1:0]            r_d;
    logic [LMW-1:0]            r_len;
    logic [PW-1:0]             r_p;
    logic [QW-1:0]             r_q;
    logic [RW-1:0]             r_rem;
    logic                      r_neg;
    logic signed [SAMPLE_W-1:0] r_sample;
    logic                      r_seg_started;

    t_alu_op                   alu_op;
    logic [PW-1:0]             alu_a;
    logic [PW-1:0]             alu_b;
    logic [PW-1:0]             alu_y;

    logic                      in_accept;
    logic                      out_free;
    logic                      started;
    logic                      last_mul;
    logic                      last_div;
    logic [MUL_IDX_W-1:0]      mul_idx;
    logic [LMW-1:0]            min_m;
    logic [LMW-1:0]            max_m;
    logic [LMW-1:0]            lo_m;
    logic [LMW-1:0]            hi_m;
    logic [LMW-1:0]            len_sum;
    logic [LMW-1:0]            len_v;
    logic signed [RAND_W:0]    delta;
    logic [RAND_W-1:0]         abs_d;
    logic [QW-1:0]             mag;
    logic signed [AW-1:0]      acc_init;
    logic [PW-1:0]             acc_ext;
    logic [PW-1:0]             slope_ext;
    logic [RW-1:0]             rem_sh;
    logic signed [PW-1:0]      p_sh;
    logic signed [SAMPLE_W-1:0] sat_v;

    rsdg_alu #(
        .W (PW)
    ) u_alu (
        .i_op (alu_op),
        .i_a  (alu_a),
        .i_b  (alu_b),
        .o_y  (alu_y)
    );

    assign in_accept = i_in_valid && o_in_ready;
    assign out_free  = !r_out_valid || i_out_ready;
    assign started   = r_count >= r_seg_len;
    assign mul_idx   = r_step[MUL_IDX_W-1:0];
    assign last_mul  = r_step == STEP_W'(MUL_STEPS - 1);
    assign last_div  = r_step == STEP_W'(QW - 1);

    assign min_m = LMW'(r_min_len);
    assign max_m = LMW'(r_max_len);
    assign lo_m  = (min_m > max_m) ? max_m : min_m;
    assign hi_m  = (min_m > max_m) ? min_m : max_m;

    assign len_sum = alu_y[LMW-1:0];
    assign len_v   = (len_sum == '0) ? LMW'(1) : len_sum;

    assign delta    = $signed({r_new_level[RAND_W-1], r_new_level})
                    - $signed({r_target[RAND_W-1], r_target});
    assign abs_d    = delta[RAND_W] ? RAND_W'(-delta) : delta[RAND_W-1:0];
    assign mag      = QW'(abs_d) << LEVEL_SHIFT;
    assign acc_init = {{(AW-RAND_W){r_target[RAND_W-1]}}, r_target} <<< LEVEL_SHIFT;

    assign acc_ext   = {{(PW-AW){r_acc[AW-1]}}, r_acc};
    assign slope_ext = {{(PW-AW){r_slope[AW-1]}}, r_slope};
    assign rem_sh    = {r_rem[LMW-1:0], r_q[QW-1]};

    assign p_sh = $signed(r_p) >>> OUT_SHIFT;

    always_comb begin
        if (p_sh > SAT_HI) begin
            sat_v = SAMPLE_W'(SAT_HI);
        end else if (p_sh < SAT_LO) begin
            sat_v = SAMPLE_W'(SAT_LO);
        end else begin
            sat_v = p_sh[SAMPLE_W-1:0];
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (in_accept) begin
                    n_state = started ? ST_DIFF : ST_OMUL;
                end
            end
            ST_DIFF: n_state = ST_LMUL;
            ST_LMUL: begin
                if (last_mul) begin
                    n_state = ST_LEN;
                end
            end
            ST_LEN:  n_state = ST_DIV;
            ST_DIV: begin
                if (last_div) begin
                    n_state = ST_NEG;
                end
            end
            ST_NEG:  n_state = ST_OMUL;
            ST_OMUL: begin
                if (last_mul) begin
                    n_state = ST_FIN;
                end
            end
            ST_FIN: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready = 1'b0;
        alu_op     = ALU_ADD;
        alu_a      = '0;
        alu_b      = '0;
        unique case (r_state)
            ST_IDLE: o_in_ready = 1'b1;
            ST_DIFF: begin
                alu_op = ALU_SUB;
                alu_a  = PW'(hi_m);
                alu_b  = PW'(lo_m);
            end
            ST_LMUL: begin
                alu_a = r_p;
                alu_b = r_frac[mul_idx] ? (PW'(r_d) << mul_idx) : '0;
            end
            ST_LEN: begin
                alu_a = PW'(lo_m);
                alu_b = PW'(r_p[LMW+15:16]);
            end
            ST_DIV: begin
                alu_op = ALU_SUB;
                alu_a  = PW'(rem_sh);
                alu_b  = PW'(r_len);
            end
            ST_NEG: begin
                alu_op = ALU_SUB;
                alu_b  = PW'(r_q);
            end
            ST_OMUL: begin
                alu_a = r_p;
                alu_b = r_gain[mul_idx] ? (acc_ext << mul_idx) : '0;
            end
            ST_FIN: begin
                alu_a = acc_ext;
                alu_b = slope_ext;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_gain      <= GAIN_RST;
            r_min_len   <= MIN_LEN_RST;
            r_max_len   <= MAX_LEN_RST;
            r_acc       <= '0;
            r_slope     <= '0;
            r_target    <= '0;
            r_count     <= '0;
            r_seg_len   <= '0;
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_GAIN:    r_gain    <= i_cfg_data[GAIN_W-1:0];
                    CFG_MIN_LEN: r_min_len <= i_cfg_data;
                    CFG_MAX_LEN: r_max_len <= i_cfg_data;
                    default: ;
                endcase
            end
            if (r_state == ST_LMUL || r_state == ST_OMUL) begin
                r_step <= last_mul ? '0 : r_step + STEP_W'(1);
            end else if (r_state == ST_DIV) begin
                r_step <= last_div ? '0 : r_step + STEP_W'(1);
            end else begin
                r_step <= '0;
            end
            if (r_state == ST_LEN) begin
                r_target  <= r_new_level;
                r_acc     <= acc_init;
                r_count   <= '0;
                r_seg_len <= LENGTH_BITS'(len_v);
            end
            if (r_state == ST_NEG) begin
                r_slope <= r_neg ? $signed(alu_y[AW-1:0]) : $signed(AW'(r_q));
            end
            if (r_state == ST_FIN && out_free) begin
                r_acc       <= $signed(alu_y[AW-1:0]);
                r_count     <= r_count + LENGTH_BITS'(1);
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_frac      <= i_rand_length;
            r_new_level <= i_rand_level;
            r_started   <= started;
            r_p         <= '0;
        end
        unique case (r_state)
            ST_DIFF: begin
                r_d <= alu_y[LMW-1:0];
                r_p <= '0;
            end
            ST_LMUL: r_p <= alu_y;
            ST_LEN: begin
                r_len <= len_v;
                r_q   <= mag;
                r_rem <= '0;
                r_neg <= delta[RAND_W];
            end
            ST_DIV: begin
                if (!alu_y[PW-1]) begin
                    r_rem <= alu_y[RW-1:0];
                    r_q   <= {r_q[QW-2:0], 1'b1};
                end else begin
                    r_rem <= rem_sh;
                    r_q   <= {r_q[QW-2:0], 1'b0};
                end
            end
            ST_NEG:  r_p <= '0;
            ST_OMUL: r_p <= alu_y;
            ST_FIN: begin
                if (out_free) begin
                    r_sample      <= sat_v;
                    r_seg_started <= r_started;
                end
            end
            default: ;
        endcase
    end

    assign o_out_valid       = r_out_valid;
    assign o_sample          = r_sample;
    assign o_segment_started = r_seg_started;

endmodule

`default_nettype wire

// ===== rtl/rsdg_checker.sv =====
// ----------------------------------------------------------------------------
// Random segment drift generator checker
// Concurrent checks on the top level ports, attached by a bind statement.
// ----------------------------------------------------------------------------
`default_nettype none

module rsdg_checker
    import rsdg_pkg::*;
(
    input wire                          i_clk,
    input wire                          i_rst_n,
    input wire                          i_in_valid,
    input wire                          o_in_ready,
    input wire                          o_out_valid,
    input wire                          i_out_ready,
    input wire logic signed [SAMPLE_W-1:0] o_sample,
    input wire                          o_segment_started
);

    // A sample tick transaction keeps the sequencer busy on the next cycle.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("block still ready right after a transaction");

    // A new result appears only as the sequencer returns to ready.
    a_result_with_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> o_in_ready)
        else $error("result appeared while the block was busy");

    // No result can finish in the cycle after a tick is taken.
    a_no_instant_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |-> ##1 !$rose(o_out_valid))
        else $error("result finished too early");

    // A stalled result holds its payload.
    a_result_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=>
            (o_out_valid && $stable(o_sample) && $stable(o_segment_started)))
        else $error("stalled result changed");

endmodule

bind random_segment_drift_generator_top rsdg_checker u_rsdg_checker (.*);

`default_nettype wire

// ===== tb/sv/random_segment_drift_generator_top_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Random segment drift generator testbench
// Sends sample tick transactions with random length and level values, keeps
// a software copy of the segment and interpolation arithmetic,
// and checks every output sample and new-segment flag in order. The run
// sweeps gain and segment length settings, including swapped and zero
// lengths and the widest range, under several input and output idle patterns.
// It also holds the output off for a long stretch.
// ----------------------------------------------------------------------------

module random_segment_drift_generator_top_tb;
    import rsdg_pkg::*;

    localparam int     CLK_PERIOD   = 10;
    localparam int     CYCLE_LIMIT  = 2_000_000;
    localparam int     SETTLE_CYCLES = 100;
    localparam int     HOLD_CYCLES  = 600;
    localparam int     MAX_GAP      = 30;
    localparam longint LEVEL_SCALE  = 131072;
    localparam int     OUT_SHIFT    = 33;
    localparam int     LEN_MASK     = 20'hFFFFF;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
        logic                       started;
    } t_drift_result;

    logic                         i_clk;
    logic                         i_rst_n;
    logic                         i_cfg_we;
    logic [CFG_IDX_W-1:0]         i_cfg_index;
    logic [CFG_DATA_W-1:0]        i_cfg_data;
    logic                         i_in_valid;
    logic                         o_in_ready;
    logic [RAND_W-1:0]            i_rand_length;
    logic signed [RAND_W-1:0]     i_rand_level;
    logic                         o_out_valid;
    logic                         i_out_ready = 1'b0;
    logic signed [SAMPLE_W-1:0]   o_sample;
    logic                         o_segment_started;

    int cfg_gain    = GAIN_RST;
    int cfg_min_len = MIN_LEN_RST;
    int cfg_max_len = MAX_LEN_RST;

    longint acc_level  = 0;
    longint step_level = 0;
    int     end_level  = 0;
    int     ticks_done = 0;
    int     seg_ticks  = 0;

    t_drift_result pending_samples[$];

    int tx_idle_pct  = 0;
    int rx_stall_pct = 0;
    bit rx_hold      = 1'b0;
    int cycle_count  = 0;
    int items_sent   = 0;
    int samples_checked = 0;
    int segments_seen = 0;
    int fail_count   = 0;
    event hold_trigger;

    random_segment_drift_generator_top u_dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .i_in_valid        (i_in_valid),
        .o_in_ready        (o_in_ready),
        .i_rand_length     (i_rand_length),
        .i_rand_level      (i_rand_level),
        .o_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .o_sample          (o_sample),
        .o_segment_started (o_segment_started)
    );

    initial begin
        i_clk = 1'b0;
        forever #(CLK_PERIOD / 2) i_clk = ~i_clk;
    end

    function automatic t_drift_result predict_drift_sample(
        input logic [RAND_W-1:0] frac,
        input logic signed [RAND_W-1:0] new_level);
        t_drift_result r;
        int     lo;
        int     hi;
        int     new_lvl;
        int     delta;
        longint span;
        longint seg_len;
        longint mag;
        longint quot;
        longint prod;
        longint level_out;
        new_lvl   = new_level;
        r.started = (ticks_done >= seg_ticks);
        if (r.started) begin
            lo = cfg_min_len;
            hi = cfg_max_len;
            if (lo > hi) begin
                lo = cfg_max_len;
                hi = cfg_min_len;
            end
            span    = hi - lo;
            seg_len = lo + ((span * longint'(frac)) >> 16);
            if (seg_len == 0) begin
                seg_len = 1;
            end
            acc_level  = longint'(end_level) * LEVEL_SCALE;
            delta      = new_lvl - end_level;
            mag        = (delta < 0) ? -longint'(delta) : longint'(delta);
            mag        = mag * LEVEL_SCALE;
            quot       = mag / seg_len;
            step_level = (delta < 0) ? -quot : quot;
            end_level  = new_lvl;
            ticks_done = 0;
            seg_ticks  = int'(seg_len) & LEN_MASK;
        end
        prod      = acc_level * longint'(cfg_gain);
        level_out = prod >>> OUT_SHIFT;
        if (level_out > 32767) begin
            level_out = 32767;
        end
        if (level_out < -32768) begin
            level_out = -32768;
        end
        r.sample   = level_out[SAMPLE_W-1:0];
        acc_level  = acc_level + step_level;
        ticks_done = (ticks_done + 1) & LEN_MASK;
        return r;
    endfunction

    always @(posedge i_clk) begin : check_proc
        t_drift_result want;
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) begin
                samples_checked++;
                if (o_segment_started) begin
                    segments_seen++;
                end
                if (pending_samples.size() == 0) begin
                    fail_count++;
                    $display("%0t: unexpected output transaction, sample %0d started %0b",
                             $time, o_sample, o_segment_started);
                end else begin
                    want = pending_samples.pop_front();
                    if (o_sample !== want.sample) begin
                        fail_count++;
                        $display("%0t: sample mismatch, expected %0d actual %0d",
                                 $time, want.sample, o_sample);
                    end
                    if (o_segment_started !== want.started) begin
                        fail_count++;
                        $display("%0t: segment_started mismatch, expected %0b actual %0b",
                                 $time, want.started, o_segment_started);
                    end
                end
            end
            if (i_in_valid && o_in_ready) begin
                pending_samples.push_back(predict_drift_sample(i_rand_length, i_rand_level));
            end
        end
    end

    always @(negedge i_clk) begin
        i_out_ready <= rx_hold ? 1'b0 : ($urandom_range(99) >= rx_stall_pct);
    end

    initial begin
        forever begin
            @(hold_trigger);
            rx_hold = 1'b1;
            repeat (HOLD_CYCLES) @(posedge i_clk);
            rx_hold = 1'b0;
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("%0t: timeout after %0d cycles, %0d samples outstanding",
                     $time, cycle_count, pending_samples.size());
            $display("Test completed with failures");
            $finish;
        end
    end

    task automatic write_reg(input t_cfg_reg idx, input logic [CFG_DATA_W-1:0] value);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        @(posedge i_clk);
        case (idx)
            CFG_GAIN:    cfg_gain = value[GAIN_W-1:0];
            CFG_MIN_LEN: cfg_min_len = value;
            CFG_MAX_LEN: cfg_max_len = value;
            default:     ;
        endcase
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic write_lengths(input int min_len, input int max_len);
        write_reg(CFG_MIN_LEN, min_len[CFG_DATA_W-1:0]);
        write_reg(CFG_MAX_LEN, max_len[CFG_DATA_W-1:0]);
    endtask

    task automatic send_tick(input logic [RAND_W-1:0] frac, input logic [RAND_W-1:0] level);
        int gap;
        gap = 0;
        while (gap < MAX_GAP && $urandom_range(99) < tx_idle_pct) begin
            gap++;
        end
        @(negedge i_clk);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_rand_length <= frac;
        i_rand_level  <= level;
        do @(posedge i_clk); while (!o_in_ready);
        items_sent++;
    endtask

    task automatic settle();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (pending_samples.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic test_reset_gain();
        write_lengths(1, 1);
        send_tick(16'h0000, 16'h7FFF);
        send_tick(16'hFFFF, 16'h8000);
        send_tick(16'h0000, 16'h0000);
        send_tick(16'hFFFF, 16'hFFFF);
        settle();
    endtask

    task automatic test_gain_extremes();
        write_reg(CFG_GAIN, 20'hFFFF);
        send_tick(16'h8000, 16'h7FFF);
        send_tick(16'h0001, 16'h8000);
        send_tick(16'h5555, 16'h7FFF);
        settle();
        write_reg(CFG_GAIN, 20'h0);
        send_tick(16'hAAAA, 16'h8001);
        send_tick(16'h0000, 16'h7FFE);
        settle();
    endtask

    task automatic test_zero_length();
        write_reg(CFG_GAIN, 20'hFFFF);
        write_lengths(0, 0);
        send_tick(16'hFFFF, 16'h4000);
        send_tick(16'h0000, 16'hC000);
        settle();
        write_lengths(0, 4);
        send_tick(16'h0000, 16'h1234);
        settle();
    endtask

    task automatic test_swapped_lengths();
        write_lengths(9, 3);
        send_tick(16'h0000, 16'h7FFF);
        send_tick(16'h2222, 16'h8000);
        send_tick(16'h3333, 16'h0101);
        send_tick(16'hFFFF, 16'hFEFE);
        settle();
    endtask

    task automatic test_midsegment_config();
        write_reg(CFG_GAIN, 20'h9000);
        write_lengths(6, 6);
        repeat (3) send_tick(16'($urandom), 16'($urandom));
        settle();
        write_reg(CFG_GAIN, 20'h2345);
        write_lengths(2, 2);
        repeat (5) send_tick(16'($urandom), 16'($urandom));
        settle();
    endtask

    task automatic test_backpressure();
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
        write_reg(CFG_GAIN, 20'hC000);
        write_lengths(3, 5);
        -> hold_trigger;
        repeat (40) send_tick(16'($urandom), 16'($urandom));
        settle();
    endtask

    task automatic pick_random_config();
        int min_len;
        int max_len;
        case ($urandom_range(3))
            0:       write_reg(CFG_GAIN, 20'h0);
            1:       write_reg(CFG_GAIN, 20'hFFFF);
            default: write_reg(CFG_GAIN, 20'($urandom_range(65535)));
        endcase
        min_len = $urandom_range(1, 48);
        max_len = $urandom_range(1, 48);
        if ($urandom_range(5) == 0) begin
            min_len = 1;
            max_len = 1;
        end
        write_lengths(min_len, max_len);
    endtask

    task automatic test_random_drift(input int idle_pct, input int stall_pct, input int count);
        logic [RAND_W-1:0] frac;
        tx_idle_pct  = idle_pct;
        rx_stall_pct = stall_pct;
        repeat (2) begin
            pick_random_config();
            repeat (count / 2) begin
                case ($urandom_range(9))
                    0:       frac = 16'h0000;
                    1:       frac = 16'hFFFF;
                    default: frac = 16'($urandom);
                endcase
                send_tick(frac, 16'($urandom));
            end
            settle();
        end
    endtask

    task automatic test_long_segment();
        tx_idle_pct  = 14;
        rx_stall_pct = 14;
        write_reg(CFG_GAIN, 20'hFFFF);
        write_lengths(20'hFFFFF, 1);
        send_tick(16'hFFFF, 16'h8000);
        repeat (24) send_tick(16'($urandom), 16'($urandom));
        settle();
    endtask

    initial begin
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_index   = CFG_GAIN;
        i_cfg_data    = '0;
        i_in_valid    = 1'b0;
        i_rand_length = '0;
        i_rand_level  = '0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_gain();
        test_gain_extremes();
        test_zero_length();
        test_swapped_lengths();
        test_midsegment_config();
        test_backpressure();
        test_random_drift(0, 0, 500);
        test_random_drift(60, 0, 500);
        test_random_drift(0, 60, 500);
        test_random_drift(14, 14, 500);
        test_long_segment();

        $display("Sent %0d tick transactions and checked %0d samples, %0d of them new segments,",
                 items_sent, samples_checked, segments_seen);
        $display("over gain and length sweeps, idle patterns and a long output hold.");
        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

// ===== random_segment_drift_generator_top.f =====
rtl/rsdg_pkg.sv
rtl/rsdg_alu.sv
rtl/random_segment_drift_generator_top.sv
rtl/rsdg_checker.sv
tb/sv/random_segment_drift_generator_top_tb.sv
